// ===== hw/rtl/pdf_pkg.sv =====
package pdf_pkg;

  // Width of a register specifier and of a data word.
  localparam int unsigned REG_W  = 4;
  localparam int unsigned DATA_W = 64;

  // Instruction codes of the decode and execute stages.
  localparam logic [REG_W-1:0] IC_NOP    = 4'd1;
  localparam logic [REG_W-1:0] IC_RRMOVQ = 4'd2;
  localparam logic [REG_W-1:0] IC_IRMOVQ = 4'd3;
  localparam logic [REG_W-1:0] IC_RMMOVQ = 4'd4;
  localparam logic [REG_W-1:0] IC_MRMOVQ = 4'd5;
  localparam logic [REG_W-1:0] IC_OPQ    = 4'd6;
  localparam logic [REG_W-1:0] IC_JXX    = 4'd7;
  localparam logic [REG_W-1:0] IC_CALL   = 4'd8;
  localparam logic [REG_W-1:0] IC_RET    = 4'd9;
  localparam logic [REG_W-1:0] IC_PUSHQ  = 4'd10;
  localparam logic [REG_W-1:0] IC_POPQ   = 4'd11;

  // Register numbers with a fixed role.
  localparam logic [REG_W-1:0] R_SP   = 4'd4;
  localparam logic [REG_W-1:0] R_NONE = 4'd15;

  // Source register for valA.
  function automatic logic [REG_W-1:0] dec_src_a(input logic [REG_W-1:0] ic,
                                                input logic [REG_W-1:0] ra);
    logic [REG_W-1:0] r;
    case (ic)
      IC_RRMOVQ, IC_RMMOVQ, IC_OPQ, IC_PUSHQ: r = ra;
      IC_POPQ, IC_RET:                        r = R_SP;
      default:                                r = R_NONE;
    endcase
    return r;
  endfunction

  // Source register for valB.
  function automatic logic [REG_W-1:0] dec_src_b(input logic [REG_W-1:0] ic,
                                                input logic [REG_W-1:0] rb);
    logic [REG_W-1:0] r;
    case (ic)
      IC_MRMOVQ, IC_RMMOVQ, IC_OPQ:         r = rb;
      IC_PUSHQ, IC_POPQ, IC_CALL, IC_RET:   r = R_SP;
      default:                              r = R_NONE;
    endcase
    return r;
  endfunction

  // Destination of the ALU result.
  function automatic logic [REG_W-1:0] dec_dst_e(input logic [REG_W-1:0] ic,
                                                input logic [REG_W-1:0] rb);
    logic [REG_W-1:0] r;
    case (ic)
      IC_RRMOVQ, IC_IRMOVQ, IC_OPQ:         r = rb;
      IC_PUSHQ, IC_POPQ, IC_CALL, IC_RET:   r = R_SP;
      default:                              r = R_NONE;
    endcase
    return r;
  endfunction

  // Destination of the memory load.
  function automatic logic [REG_W-1:0] dec_dst_m(input logic [REG_W-1:0] ic,
                                                input logic [REG_W-1:0] ra);
    logic [REG_W-1:0] r;
    case (ic)
      IC_MRMOVQ, IC_POPQ: r = ra;
      default:            r = R_NONE;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/pipeline_decode_forwarding_core.sv =====
// Decode stage of a five-stage pipelined processor: register selection,
// operand forwarding and hazard flags.
// Input channel (in_valid/in_ready): one word per processor cycle while
// in_ready is high, carrying the decode instruction's fields, the
// execute-stage results and the value read by the memory stage. Result
// channel (out_valid/out_ready): one word per input word, in order, with
// srcA, srcB, dstE, dstM, valA, valB and the load-use stall and bubble flags.
// The accepting edge decodes the sources and reads the register file into
// the input register; when the word moves on, it is forwarded and flagged
// into the output register. Throughput is one word per cycle while the
// receiver takes every output word.
// The block holds the register file (15 entries) and the memory and
// write-back stage destinations and values, which shift once per word.
// Reset (rst_n low at a clock edge) makes the register file read zero, sets the
// stage registers to nop with no destinations, and empties both registers.
// When the receiver stalls, the output word holds; one more word is taken
// into the input register, after which in_ready stays low until the
// receiver takes the output word.
module pipeline_decode_forwarding_core
  import pdf_pkg::*;
#(
  parameter int unsigned REG_COUNT = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REG_W-1:0]  in_instr_code,
  input  logic [REG_W-1:0]  in_reg_a_field,
  input  logic [REG_W-1:0]  in_reg_b_field,
  input  logic [DATA_W-1:0] in_next_pc,
  input  logic [REG_W-1:0]  in_exec_instr_code,
  input  logic [REG_W-1:0]  in_exec_dest_alu,
  input  logic [DATA_W-1:0] in_exec_alu_value,
  input  logic [REG_W-1:0]  in_exec_dest_load,
  input  logic              in_exec_condition,
  input  logic [DATA_W-1:0] in_mem_read_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [REG_W-1:0]  out_source_a,
  output logic [REG_W-1:0]  out_source_b,
  output logic [REG_W-1:0]  out_dest_alu,
  output logic [REG_W-1:0]  out_dest_load,
  output logic [DATA_W-1:0] out_operand_a,
  output logic [DATA_W-1:0] out_operand_b,
  output logic              out_stall_res,
  output logic              out_bubble
);

  // Handshake control.
  logic in_vld_r;
  logic out_vld_r;
  logic adv;
  logic in_fire;

  // Input register.
  logic [REG_W-1:0]  ic_r, sa_r, sb_r, de_r, dm_r;
  logic [DATA_W-1:0] valp_r;
  logic [REG_W-1:0]  e_ic_r, e_dste_r, e_dstm_r;
  logic [DATA_W-1:0] e_vale_r, m_valm_r;
  logic              e_cnd_r;
  logic [DATA_W-1:0] rda_r, rdb_r;

  // Memory and write-back stage state.
  logic [REG_W-1:0]  mem_icode_r, mem_dest_alu_r, mem_dest_load_r;
  logic [DATA_W-1:0] mem_alu_value_r;
  logic [REG_W-1:0]  wb_dest_alu_r, wb_dest_load_r;
  logic [DATA_W-1:0] wb_alu_value_r, wb_load_value_r;

  // Register file with a valid bit per entry; an entry never written reads zero.
  logic [DATA_W-1:0]    rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_r;

  // Decode of the arriving word.
  logic [REG_W-1:0] dec_sa, dec_sb;

  // Second-stage results.
  logic [DATA_W-1:0] fwd_a, fwd_b, va_nxt;
  logic              e_load, load_use, ret_fly, bub_nxt;

  // Output register.
  logic [REG_W-1:0]  out_sa_r, out_sb_r, out_de_r, out_dm_r;
  logic [DATA_W-1:0] out_va_r, out_vb_r;
  logic              out_stall_r, out_bub_r;

  // A word moves on whenever the output register is free or being emptied.
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;
  assign in_fire  = in_valid && in_ready;

  assign dec_sa = dec_src_a(in_instr_code, in_reg_a_field);
  assign dec_sb = dec_src_b(in_instr_code, in_reg_b_field);

  // Valid bits of the two registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_fire) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Input register, with the decoded sources and destinations.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ic_r     <= in_instr_code;
      sa_r     <= dec_sa;
      sb_r     <= dec_sb;
      de_r     <= dec_dst_e(in_instr_code, in_reg_b_field);
      dm_r     <= dec_dst_m(in_instr_code, in_reg_a_field);
      valp_r   <= in_next_pc;
      e_ic_r   <= in_exec_instr_code;
      e_dste_r <= in_exec_dest_alu;
      e_vale_r <= in_exec_alu_value;
      e_dstm_r <= in_exec_dest_load;
      e_cnd_r  <= in_exec_condition;
      m_valm_r <= in_mem_read_value;
    end
  end

  // Register-file reads. The write-back of the word leaving at this edge is
  // bypassed, the load port taking precedence as it does in the write.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (int'(dec_sa) >= REG_COUNT) begin
        rda_r <= '0;
      end else if (adv && dec_sa == wb_dest_load_r) begin
        rda_r <= wb_load_value_r;
      end else if (adv && dec_sa == wb_dest_alu_r) begin
        rda_r <= wb_alu_value_r;
      end else if (rf_vld_r[dec_sa]) begin
        rda_r <= rf_mem[dec_sa];
      end else begin
        rda_r <= '0;
      end
      if (int'(dec_sb) >= REG_COUNT) begin
        rdb_r <= '0;
      end else if (adv && dec_sb == wb_dest_load_r) begin
        rdb_r <= wb_load_value_r;
      end else if (adv && dec_sb == wb_dest_alu_r) begin
        rdb_r <= wb_alu_value_r;
      end else if (rf_vld_r[dec_sb]) begin
        rdb_r <= rf_mem[dec_sb];
      end else begin
        rdb_r <= '0;
      end
    end
  end

  // Register-file writes from the write-back stage; the load port wins when
  // both ports name the same register.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (int'(wb_dest_alu_r) < REG_COUNT && wb_dest_alu_r != wb_dest_load_r) begin
        rf_mem[wb_dest_alu_r] <= wb_alu_value_r;
      end
      if (int'(wb_dest_load_r) < REG_COUNT) begin
        rf_mem[wb_dest_load_r] <= wb_load_value_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (adv) begin
      if (int'(wb_dest_alu_r) < REG_COUNT && wb_dest_alu_r != wb_dest_load_r) begin
        rf_vld_r[wb_dest_alu_r] <= 1'b1;
      end
      if (int'(wb_dest_load_r) < REG_COUNT) begin
        rf_vld_r[wb_dest_load_r] <= 1'b1;
      end
    end
  end

  // Forwarding in priority order: execute, memory load, memory ALU,
  // write-back load, write-back ALU, then the register file.
  always_comb begin
    if (sa_r == e_dste_r) begin
      fwd_a = e_vale_r;
    end else if (sa_r == mem_dest_load_r) begin
      fwd_a = m_valm_r;
    end else if (sa_r == mem_dest_alu_r) begin
      fwd_a = mem_alu_value_r;
    end else if (sa_r == wb_dest_load_r) begin
      fwd_a = wb_load_value_r;
    end else if (sa_r == wb_dest_alu_r) begin
      fwd_a = wb_alu_value_r;
    end else begin
      fwd_a = rda_r;
    end
  end

  always_comb begin
    if (sb_r == e_dste_r) begin
      fwd_b = e_vale_r;
    end else if (sb_r == mem_dest_load_r) begin
      fwd_b = m_valm_r;
    end else if (sb_r == mem_dest_alu_r) begin
      fwd_b = mem_alu_value_r;
    end else if (sb_r == wb_dest_load_r) begin
      fwd_b = wb_load_value_r;
    end else if (sb_r == wb_dest_alu_r) begin
      fwd_b = wb_alu_value_r;
    end else begin
      fwd_b = rdb_r;
    end
  end

  // Calls and jumps carry valP in valA.
  assign va_nxt = (ic_r == IC_CALL || ic_r == IC_JXX) ? valp_r : fwd_a;

  // Hazard flags: a load in execute feeding a source stalls decode; a
  // mispredicted jump, or a return in flight with no load-use stall, inserts a bubble.
  assign e_load   = (e_ic_r == IC_MRMOVQ) || (e_ic_r == IC_POPQ);
  assign load_use = e_load && (e_dstm_r == sa_r || e_dstm_r == sb_r);
  assign ret_fly  = (ic_r == IC_RET) || (e_ic_r == IC_RET) || (mem_icode_r == IC_RET);
  assign bub_nxt  = (e_ic_r == IC_JXX && !e_cnd_r) || (!load_use && ret_fly);

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_sa_r    <= sa_r;
      out_sb_r    <= sb_r;
      out_de_r    <= de_r;
      out_dm_r    <= dm_r;
      out_va_r    <= va_nxt;
      out_vb_r    <= fwd_b;
      out_stall_r <= load_use;
      out_bub_r   <= bub_nxt;
    end
  end

  // Stage registers shift once per word: write-back takes memory, memory
  // takes execute.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_icode_r     <= IC_NOP;
      mem_dest_alu_r  <= R_NONE;
      mem_alu_value_r <= '0;
      mem_dest_load_r <= R_NONE;
      wb_dest_alu_r   <= R_NONE;
      wb_alu_value_r  <= '0;
      wb_dest_load_r  <= R_NONE;
      wb_load_value_r <= '0;
    end else if (adv) begin
      wb_dest_alu_r   <= mem_dest_alu_r;
      wb_alu_value_r  <= mem_alu_value_r;
      wb_dest_load_r  <= mem_dest_load_r;
      wb_load_value_r <= m_valm_r;
      mem_icode_r     <= e_ic_r;
      mem_dest_alu_r  <= e_dste_r;
      mem_alu_value_r <= e_vale_r;
      mem_dest_load_r <= e_dstm_r;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_source_a  = out_sa_r;
  assign out_source_b  = out_sb_r;
  assign out_dest_alu  = out_de_r;
  assign out_dest_load = out_dm_r;
  assign out_operand_a = out_va_r;
  assign out_operand_b = out_vb_r;
  assign out_stall_res = out_stall_r;
  assign out_bubble    = out_bub_r;

  // An empty input register always takes a word.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_ready)
    else $error("input register empty but not ready");

  // A word is never taken into a full input register that is not moving on.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_vld_r) |-> adv)
    else $error("input register overwritten");

  // Every word moved on shows up as a result in the next cycle.
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid)
    else $error("moved word produced no result");

endmodule
